/* sv/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Types and constants shared by the banked memory mapper and its byte store.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

    // geometry of one bank
    localparam int unsigned BANK_BYTES = 16384;
    localparam int unsigned OFF_W      = 14;
    localparam int unsigned BANK_W     = 3;
    localparam int unsigned MEM_ADDR_W = BANK_W + OFF_W;
    localparam int unsigned NUM_PAGES  = 4;

    // request codes
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_SELECT = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ROM    = 2'd1;
    localparam logic [1:0] ST_NO_CUR = 2'd2;

    // page map register bit positions
    localparam int unsigned MAP_BANKED = 3;
    localparam int unsigned MAP_ROM    = 4;

    // usage bound reset values
    localparam logic [15:0] LEAST_INIT    = 16'hFFFF;
    localparam logic [15:0] GREATEST_INIT = 16'h0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [2:0]  new_bank;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  status;
        logic [2:0]  mapped_bank;
        logic        page_was_paged;
        logic        any_paged;
        logic [2:0]  current_bank_out;
        logic [15:0] min_used;
        logic [15:0] max_used;
        logic        bank_used;
    } t_out;

    // access to the byte store
    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_req;

endpackage

`default_nettype wire

/* sv/bmm_store.sv */
// ----------------------------------------------------------------------------
// bmm_store
// Byte store of all banks: single port synchronous ram with registered read
// data, swept to zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_store
    import bmm_pkg::*;
#(
    parameter int unsigned NUM_BANKS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_rdata,
    output logic          o_busy
);

    localparam int unsigned DEPTH = NUM_BANKS * BANK_BYTES;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] req_addr;

    assign req_addr = i_req.addr[AW-1:0];

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ram write and registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.en && i_req.we) begin
            r_mem[req_addr] <= i_req.wdata;
        end
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[req_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

`default_nettype wire

/* sv/banked_memory_mapper_unit.sv */
// ----------------------------------------------------------------------------
// banked_memory_mapper_unit
// Maps 16-bit addresses onto four 16K pages backed by byte banks.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_in_valid / o_in_ready) carry a read, write, bank select
//   or usage query. Every input beat gives exactly one output beat
//   (o_out_valid / i_out_ready) holding status, mapped bank, paged flags,
//   current bank and, on a query, the usage bounds of the current bank.
//   Page map registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata;
//   the user must do so only while the block is idle; the block does not enforce it.
// Pipeline:
//   An accepted beat is mapped and its ram access issued at once; the held
//   result and the ram read data are registered, then merged into the output
//   register. A new beat is not taken while a result is pending (r_pend), so
//   one item is in flight at a time.
// Reset:
//   Page maps return to banks 0..3, flags and bounds clear, and the byte
//   store is swept to zero one byte a cycle, with o_in_ready low during the sweep.
// Stalls:
//   A finished result waits in the output register; the next beat is taken
//   in the same cycle that the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_memory_mapper_unit
    import bmm_pkg::*;
#(
    parameter int unsigned NUM_BANKS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_wdata
);

    localparam int unsigned BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    // bank index reduced into range
    function automatic logic [2:0] wrap_bank(input logic [2:0] b);
        logic [3:0] r;
        r = {1'b0, b};
        for (int k = 0; k < 7; k++) begin
            if (r >= 4'(NUM_BANKS)) begin
                r = r - 4'(NUM_BANKS);
            end
        end
        return r[2:0];
    endfunction

    // mapping state
    logic [2:0]  r_page_bank   [NUM_PAGES];
    logic        r_page_banked [NUM_PAGES];
    logic        r_page_rom    [NUM_PAGES];
    logic        r_page_paged  [NUM_PAGES];
    logic [2:0]  r_cur_bank;
    logic        r_cur_valid;
    logic        r_global_paged;
    logic [15:0] r_least    [NUM_BANKS];
    logic [15:0] r_greatest [NUM_BANKS];

    // result path
    logic        r_pend;
    logic        r_rd_en;
    t_out        r_hold;
    t_out        r_out;
    logic        r_out_valid;

    // next values
    logic [2:0]  n_page_bank  [NUM_PAGES];
    logic        n_page_paged [NUM_PAGES];
    logic [2:0]  n_cur_bank;
    logic        n_cur_valid;
    logic        n_global_paged;
    logic [15:0] n_least    [NUM_BANKS];
    logic [15:0] n_greatest [NUM_BANKS];
    logic        n_rd_en;
    t_out        n_hold;
    t_out        n_out;
    t_mem_req    mem_req;

    logic        accept;
    logic        store_busy;
    logic [7:0]  mem_rdata;
    logic [1:0]  page;
    logic [2:0]  eff_bank;
    logic [2:0]  bank;
    logic [BW-1:0] bank_idx;
    logic [BW-1:0] cur_idx;

    assign o_in_ready = !store_busy && !r_pend && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // mapping, bounds and flag updates for the accepted beat
    always_comb begin
        for (int p = 0; p < NUM_PAGES; p++) begin
            n_page_bank[p]  = r_page_bank[p];
            n_page_paged[p] = r_page_paged[p];
        end
        for (int b = 0; b < NUM_BANKS; b++) begin
            n_least[b]    = r_least[b];
            n_greatest[b] = r_greatest[b];
        end
        n_cur_bank     = r_cur_bank;
        n_cur_valid    = r_cur_valid;
        n_global_paged = r_global_paged;
        n_rd_en        = 1'b0;
        n_hold         = '0;
        mem_req        = '0;

        page     = i_in_data.address[15:14];
        eff_bank = r_cur_valid ? r_cur_bank : r_page_bank[page];
        bank     = r_page_banked[page] ? eff_bank : r_page_bank[page];
        bank_idx = bank[BW-1:0];
        cur_idx  = r_cur_bank[BW-1:0];

        unique case (i_in_data.req_type)
            REQ_READ, REQ_WRITE: begin
                if (r_page_rom[page]) begin
                    n_hold.status = ST_ROM;
                end else begin
                    if (r_page_banked[page]) begin
                        n_cur_bank  = eff_bank;
                        n_cur_valid = 1'b1;
                        if (eff_bank != r_page_bank[page]) begin
                            n_page_paged[page] = 1'b1;
                            n_page_bank[page]  = eff_bank;
                            n_global_paged     = 1'b1;
                        end
                    end
                    if (i_in_data.address > r_greatest[bank_idx]) begin
                        n_greatest[bank_idx] = i_in_data.address;
                    end
                    if (i_in_data.address < r_least[bank_idx]) begin
                        n_least[bank_idx] = i_in_data.address;
                    end
                    mem_req.en    = accept;
                    mem_req.we    = (i_in_data.req_type == REQ_WRITE);
                    mem_req.addr  = {bank, i_in_data.address[OFF_W-1:0]};
                    mem_req.wdata = i_in_data.write_data;
                    n_rd_en       = (i_in_data.req_type == REQ_READ);
                    n_hold.status = ST_OK;
                    n_hold.mapped_bank = bank;
                end
                n_hold.page_was_paged = n_page_paged[page];
            end
            REQ_SELECT: begin
                n_cur_bank  = wrap_bank(i_in_data.new_bank);
                n_cur_valid = 1'b1;
            end
            REQ_QUERY: begin
                if (!r_cur_valid) begin
                    n_hold.status = ST_NO_CUR;
                end else begin
                    n_hold.min_used  = r_least[cur_idx];
                    n_hold.max_used  = r_greatest[cur_idx];
                    n_hold.bank_used = (r_greatest[cur_idx] >= r_least[cur_idx]);
                end
            end
            default: begin
            end
        endcase

        n_hold.any_paged        = n_global_paged;
        n_hold.current_bank_out = n_cur_bank;
    end

    // page maps and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_page_bank[p]   <= wrap_bank(3'(p));
                r_page_banked[p] <= 1'b0;
                r_page_rom[p]    <= 1'b0;
                r_page_paged[p]  <= 1'b0;
            end
            r_cur_bank     <= '0;
            r_cur_valid    <= 1'b0;
            r_global_paged <= 1'b0;
        end else if (i_cfg_we) begin
            r_page_bank[i_cfg_idx]   <= wrap_bank(i_cfg_wdata[2:0]);
            r_page_banked[i_cfg_idx] <= i_cfg_wdata[MAP_BANKED];
            r_page_rom[i_cfg_idx]    <= i_cfg_wdata[MAP_ROM];
            r_page_paged[i_cfg_idx]  <= 1'b0;
        end else if (accept) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_page_bank[p]  <= n_page_bank[p];
                r_page_paged[p] <= n_page_paged[p];
            end
            r_cur_bank     <= n_cur_bank;
            r_cur_valid    <= n_cur_valid;
            r_global_paged <= n_global_paged;
        end
    end

    // per-bank usage bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_least[b]    <= LEAST_INIT;
                r_greatest[b] <= GREATEST_INIT;
            end
        end else if (accept) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_least[b]    <= n_least[b];
                r_greatest[b] <= n_greatest[b];
            end
        end
    end

    // byte store
    bmm_store #(
        .NUM_BANKS(NUM_BANKS)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_rdata(mem_rdata),
        .o_busy (store_busy)
    );

    // result in flight while the ram read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold  <= n_hold;
            r_rd_en <= n_rd_en;
        end
    end

    // merge the ram read data into the held result
    always_comb begin
        n_out           = r_hold;
        n_out.read_data = r_rd_en ? mem_rdata : 8'd0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for banked_memory_mapper_unit. A scoreboard class keeps
// its own copy of the page maps, bank bytes, usage bounds and paged flags,
// predicts one response per request beat and checks the response beats in
// order. Directed requests cover ROM refusal, adoption of a current bank,
// paging, select and query with and without a current bank; random phases
// with fresh page maps and random idling on both sides follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import bmm_pkg::*;
;

    localparam int unsigned NUM_BANKS   = 8;
    localparam int unsigned HALF_PERIOD = 5;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASE_BEATS = 75;
    localparam int unsigned RAND_PHASES = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [4:0] i_cfg_wdata;

    // no idling on either side while set
    logic        quiet;
    int unsigned cycles;

    banked_memory_mapper_unit #(
        .NUM_BANKS(NUM_BANKS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // mapper state mirror and response checker
    class mapper_scoreboard;
        logic [7:0]  bank_bytes [NUM_BANKS*BANK_BYTES];
        logic [15:0] least_addr [NUM_BANKS];
        logic [15:0] greatest_addr [NUM_BANKS];
        logic [2:0]  cur_bank;
        logic        cur_valid;
        logic [2:0]  page_bank [NUM_PAGES];
        logic        page_banked [NUM_PAGES];
        logic        page_rom [NUM_PAGES];
        logic        page_paged [NUM_PAGES];
        logic        global_paged;
        t_out        expected_responses [$];
        int unsigned mismatches;

        function new();
            foreach (bank_bytes[i]) bank_bytes[i] = '0;
            foreach (least_addr[i]) begin
                least_addr[i]    = LEAST_INIT;
                greatest_addr[i] = GREATEST_INIT;
            end
            cur_bank     = '0;
            cur_valid    = 1'b0;
            global_paged = 1'b0;
            mismatches   = 0;
            for (int p = 0; p < NUM_PAGES; p++) load_page_map(p, 5'(p));
        endfunction

        function logic [2:0] wrap_bank(logic [2:0] b);
            return 3'(b % NUM_BANKS);
        endfunction

        // a map write reloads the working bank and clears the page flag
        function void load_page_map(int unsigned page, logic [4:0] value);
            page_bank[page]   = wrap_bank(value[2:0]);
            page_banked[page] = value[MAP_BANKED];
            page_rom[page]    = value[MAP_ROM];
            page_paged[page]  = 1'b0;
        endfunction

        function t_out predict_response(t_in req);
            t_out                  resp;
            logic [1:0]            page;
            logic [2:0]            bank;
            logic [MEM_ADDR_W-1:0] idx;
            resp = '0;
            case (req.req_type)
                REQ_READ, REQ_WRITE: begin
                    page = req.address[15:14];
                    if (page_rom[page]) begin
                        resp.status = ST_ROM;
                    end else begin
                        // banked page adopts or follows the current bank
                        if (page_banked[page]) begin
                            if (!cur_valid) begin
                                cur_bank  = page_bank[page];
                                cur_valid = 1'b1;
                            end
                            if (cur_bank != page_bank[page]) begin
                                page_paged[page] = 1'b1;
                                page_bank[page]  = cur_bank;
                                global_paged     = 1'b1;
                            end
                        end
                        bank = page_bank[page];
                        if (req.address > greatest_addr[bank]) greatest_addr[bank] = req.address;
                        if (req.address < least_addr[bank]) least_addr[bank] = req.address;
                        idx = {bank, req.address[OFF_W-1:0]};
                        if (req.req_type == REQ_WRITE) begin
                            bank_bytes[idx] = req.write_data;
                        end else begin
                            resp.read_data = bank_bytes[idx];
                        end
                        resp.mapped_bank = bank;
                    end
                    resp.page_was_paged = page_paged[page];
                end
                REQ_SELECT: begin
                    cur_bank  = wrap_bank(req.new_bank);
                    cur_valid = 1'b1;
                end
                REQ_QUERY: begin
                    if (!cur_valid) begin
                        resp.status = ST_NO_CUR;
                    end else begin
                        resp.min_used  = least_addr[cur_bank];
                        resp.max_used  = greatest_addr[cur_bank];
                        resp.bank_used = resp.max_used >= resp.min_used;
                    end
                end
            endcase
            resp.any_paged        = global_paged;
            resp.current_bank_out = cur_bank;
            return resp;
        endfunction

        function void note_request(t_in req);
            expected_responses.push_back(predict_response(req));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_response(t_out got);
            t_out want;
            if (expected_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response beat with nothing expected: status %0d bank %0d",
                             got.status, got.mapped_bank);
                return;
            end
            want = expected_responses.pop_front();
            compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("mapped_bank", 16'(want.mapped_bank), 16'(got.mapped_bank));
            compare_field("page_was_paged", 16'(want.page_was_paged), 16'(got.page_was_paged));
            compare_field("any_paged", 16'(want.any_paged), 16'(got.any_paged));
            compare_field("current_bank_out", 16'(want.current_bank_out),
                          16'(got.current_bank_out));
            compare_field("min_used", want.min_used, got.min_used);
            compare_field("max_used", want.max_used, got.max_used);
            compare_field("bank_used", 16'(want.bank_used), 16'(got.bank_used));
        endfunction

        function int unsigned pending();
            return expected_responses.size();
        endfunction
    endclass

    mapper_scoreboard sb;

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // watch both channels; a request beat is noted before a response is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid === 1'b1 && o_in_ready === 1'b1) sb.note_request(i_in_data);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) sb.check_response(o_out_data);
        end
    end

    function automatic int unsigned draw_hold();
        if (quiet) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [4:0] page_map(logic [2:0] bank, logic banked, logic rom);
        logic [4:0] v;
        v             = '0;
        v[2:0]        = bank;
        v[MAP_BANKED] = banked;
        v[MAP_ROM]    = rom;
        return v;
    endfunction

    function automatic logic [4:0] rand_page_map();
        return page_map(3'($urandom_range(0, 7)), $urandom_range(0, 9) < 6,
                        $urandom_range(0, 9) < 2);
    endfunction

    function automatic t_in make_request(logic [1:0] kind, logic [15:0] addr,
                                         logic [7:0] data, logic [2:0] bank);
        t_in r;
        r.req_type   = kind;
        r.address    = addr;
        r.write_data = data;
        r.new_bank   = bank;
        return r;
    endfunction

    // addresses lean toward a small pool so reads find earlier writes
    function automatic t_in rand_request();
        int unsigned k;
        int unsigned a;
        logic [1:0]  kind;
        logic [15:0] addr;
        k = $urandom_range(0, 19);
        if (k < 7) kind = REQ_READ;
        else if (k < 14) kind = REQ_WRITE;
        else if (k < 17) kind = REQ_SELECT;
        else kind = REQ_QUERY;
        a = $urandom_range(0, 9);
        if (a == 0) addr = {2'($urandom_range(0, 3)), {14{$urandom_range(0, 1) == 1}}};
        else if (a == 1) addr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else if (a < 6) addr = {2'($urandom_range(0, 3)), 9'd0, 5'($urandom_range(0, 31))};
        else addr = 16'($urandom_range(0, 65535));
        return make_request(kind, addr, 8'($urandom_range(0, 255)),
                            3'($urandom_range(0, 7)));
    endfunction

    // one request beat, after a random gap
    task automatic send_request(t_in req);
        int unsigned hold;
        hold = draw_hold();
        @(negedge i_clk);
        if (hold != 0) begin
            i_in_valid = 1'b0;
            repeat (hold) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // stop sending and let every response drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_pages(input logic [4:0] m0, m1, m2, m3);
        logic [4:0] maps [NUM_PAGES];
        maps = '{m0, m1, m2, m3};
        wait_idle();
        for (int p = 0; p < NUM_PAGES; p++) begin
            @(negedge i_clk);
            i_cfg_we    = 1'b1;
            i_cfg_idx   = 2'(p);
            i_cfg_wdata = maps[p];
            sb.load_page_map(p, maps[p]);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // response side: random stall after every beat
    initial begin
        int unsigned hold;
        i_out_ready = 1'b1;
        forever begin
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready === 1'b1));
            hold = draw_hold();
            @(negedge i_clk);
            if (hold != 0) begin
                i_out_ready = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    initial begin
        sb          = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        quiet       = 1'b0;
        cycles      = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset maps: query before any bank is current, plain pages, address extremes
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_READ, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_WRITE, 16'hFFFF, 8'hFF, 3'd7));
        send_request(make_request(REQ_READ, 16'hFFFF, 8'h00, 3'd0));
        send_request(make_request(REQ_WRITE, 16'h0000, 8'hA5, 3'd0));
        send_request(make_request(REQ_READ, 16'h0000, 8'h00, 3'd0));

        // banked pages: adopt a bank, get paged, ROM refusal, select and query
        program_pages(page_map(3'd5, 1'b1, 1'b0), page_map(3'd1, 1'b0, 1'b1),
                      page_map(3'd7, 1'b1, 1'b0), page_map(3'd3, 1'b0, 1'b0));
        send_request(make_request(REQ_WRITE, 16'h0010, 8'h3C, 3'd0));
        send_request(make_request(REQ_READ, 16'h8000, 8'h00, 3'd0));
        send_request(make_request(REQ_READ, 16'h4000, 8'h00, 3'd0));
        send_request(make_request(REQ_WRITE, 16'h4001, 8'h5A, 3'd0));
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_SELECT, 16'h0000, 8'h00, 3'd7));
        send_request(make_request(REQ_WRITE, 16'h0020, 8'h81, 3'd0));
        send_request(make_request(REQ_SELECT, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_SELECT, 16'h0000, 8'h00, 3'd3));
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_SELECT, 16'h0000, 8'h00, 3'd6));
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));

        // all ones: every page ROM
        program_pages(5'h1F, 5'h1F, 5'h1F, 5'h1F);
        send_request(make_request(REQ_READ, 16'h0000, 8'h00, 3'd0));
        send_request(make_request(REQ_WRITE, 16'h7FFF, 8'hFF, 3'd0));

        // all zeros: every page on bank 0, plain
        program_pages(5'h00, 5'h00, 5'h00, 5'h00);
        send_request(make_request(REQ_WRITE, 16'hC000, 8'h77, 3'd0));
        send_request(make_request(REQ_READ, 16'h4000, 8'h00, 3'd0));
        send_request(make_request(REQ_QUERY, 16'h0000, 8'h00, 3'd0));

        // random phases, each with fresh page maps; some with no idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_pages(rand_page_map(), rand_page_map(), rand_page_map(), rand_page_map());
            quiet = (ph == 2 || ph == RAND_PHASES - 1);
            repeat (PHASE_BEATS) send_request(rand_request());
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
